### rtl/bsbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbi_pkg
// Shared constants for the bounded stack with bottom increment.
// ----------------------------------------------------------------------------
package bsbi_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int DATA_W        = 32;
    localparam int CNT_W         = 11;
    localparam int OP_W          = 2;
    localparam int STAT_W        = 2;

    localparam logic [CNT_W-1:0] SIZE_LIMIT_RESET = 11'd1024;

    // opcodes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_INC  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

endpackage

### rtl/bsbi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbi_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bsbi_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bounded_stack_with_bottom_increment_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_with_bottom_increment_unit
// Bounded LIFO of 32-bit words with a lazy add to the bottom entries.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its result word
// (status, popped_value) appears for one cycle with done, and must be taken
// then. These commands finish straight from idle, with busy staying low:
// a push, any refused or empty command, an unused opcode, an increment
// with a zero count, and an increment that covers the whole stack. A
// successful pop and a nonzero increment of fewer entries than the stack
// holds pass through the ST_POP or ST_INC state, with busy high there,
// since the value and increment RAMs have a registered read. The pending
// increment of the top entry lives in a register, so each command needs
// at most one read of each RAM. No clearing pass is needed after reset.
module bounded_stack_with_bottom_increment_unit
    import bsbi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0] operand_value,
    input  logic [CNT_W-1:0]         entry_count,
    output logic                     done,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] popped_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CNT_W-1:0]         cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > CNT_W) ? FW : CNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_INC  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]  size_limit_reg;
    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] popped_reg, popped_next;
    logic [DATA_W-1:0] top_inc_reg, top_inc_next;
    logic [DATA_W-1:0] operand_reg, operand_next;
    logic [AW-1:0]     inc_addr_reg, inc_addr_next;

    logic              accept;
    logic              full;
    logic              cnt_lt_fill;
    logic [CW-1:0]     cnt_ext;
    logic [CW-1:0]     fill_ext;

    logic              val_we;
    logic [AW-1:0]     val_waddr;
    logic [DATA_W-1:0] val_wdata;
    logic              val_re;
    logic [AW-1:0]     val_raddr;
    logic [DATA_W-1:0] val_rdata;

    logic              inc_we;
    logic [AW-1:0]     inc_waddr;
    logic [DATA_W-1:0] inc_wdata;
    logic              inc_re;
    logic [AW-1:0]     inc_raddr;
    logic [DATA_W-1:0] inc_rdata;

    bsbi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    bsbi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_inc_ram (
        .clk   (clk),
        .we    (inc_we),
        .waddr (inc_waddr),
        .wdata (inc_wdata),
        .re    (inc_re),
        .raddr (inc_raddr),
        .rdata (inc_rdata)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign cnt_ext     = CW'(entry_count);
    assign fill_ext    = CW'(fill_reg);
    assign cnt_lt_fill = (cnt_ext < fill_ext);
    assign full        = (fill_reg >= FW'(DEPTH)) || (fill_ext >= CW'(size_limit_reg));

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        popped_next   = popped_reg;
        top_inc_next  = top_inc_reg;
        operand_next  = operand_reg;
        inc_addr_next = inc_addr_reg;

        val_we    = 1'b0;
        val_waddr = AW'(fill_reg);
        val_wdata = operand_value;
        val_re    = 1'b0;
        val_raddr = AW'(fill_reg - 1'b1);

        inc_we    = 1'b0;
        inc_waddr = AW'(fill_reg - 1'b1);
        inc_wdata = top_inc_reg;
        inc_re    = 1'b0;
        inc_raddr = AW'(fill_reg - 2'd2);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    popped_next = '0;
                    unique case (opcode)
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                // spill cached top increment, new top starts clean
                                val_we       = 1'b1;
                                inc_we       = (fill_reg != '0);
                                top_inc_next = '0;
                                fill_next    = fill_reg + 1'b1;
                                done_next    = 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                val_re     = 1'b1;
                                inc_re     = 1'b1;
                                state_next = ST_POP;
                            end
                        end
                        OP_INC:
                        begin
                            if (fill_reg == '0 || entry_count == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else if (!cnt_lt_fill)
                            begin
                                top_inc_next = top_inc_reg + operand_value;
                                done_next    = 1'b1;
                            end
                            else
                            begin
                                inc_re        = 1'b1;
                                inc_raddr     = AW'(cnt_ext - 1'b1);
                                inc_addr_next = AW'(cnt_ext - 1'b1);
                                operand_next  = operand_value;
                                state_next    = ST_INC;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                popped_next = val_rdata + top_inc_reg;
                // carry the top increment down onto the new top
                if (fill_reg > FW'(1))
                begin
                    top_inc_next = inc_rdata + top_inc_reg;
                end
                fill_next  = fill_reg - 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_INC:
            begin
                inc_we     = 1'b1;
                inc_waddr  = inc_addr_reg;
                inc_wdata  = inc_rdata + operand_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            done_reg       <= 1'b0;
            size_limit_reg <= SIZE_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                size_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        popped_reg   <= popped_next;
        top_inc_reg  <= top_inc_next;
        operand_reg  <= operand_next;
        inc_addr_reg <= inc_addr_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fill level above depth");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> (done_reg && state_reg == ST_IDLE))
        else $error("multi-cycle command did not finish with a result");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_PUSH && full) |=>
            (done_reg && status_reg == STAT_FULL && $stable(fill_reg)))
        else $error("refused push changed the stack");

    a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> (fill_reg == FW'($past(fill_reg) - 1'b1)))
        else $error("pop did not lower the fill level by one");

endmodule
